@@ rtl/core/llfl_pkg.sv @@
package llfl_pkg;

   localparam logic ACT_PUSH = 1'b0;
   localparam logic ACT_POP  = 1'b1;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      BK_IDLE = 2'd0,
      BK_LINK = 2'd1,
      BK_PAY  = 2'd2
   } back_state_type;

   typedef struct packed {
      logic        action;
      logic [63:0] push_payload;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [63:0] pop_payload;
      logic [7:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      op_type      op;
      logic [63:0] payload;
   } cmd_type;

endpackage

@@ rtl/core/llfl_front.sv @@
module llfl_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  llfl_pkg::req_type req_data,
   output logic              cmd_valid,
   output llfl_pkg::cmd_type cmd_data,
   input  logic              cmd_take
);

   llfl_pkg::cmd_type entries_ff [2];
   logic              wr_ptr_ff;
   logic              wr_ptr_in;
   logic              rd_ptr_ff;
   logic              rd_ptr_in;
   logic [1:0]        fill_ff;
   logic [1:0]        fill_in;
   logic              put;
   logic              get;
   llfl_pkg::cmd_type cmd_new;

   assign busy      = (fill_ff == 2'd2);
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd_data  = entries_ff[rd_ptr_ff];
   assign put       = start && !busy;
   assign get       = cmd_take && cmd_valid;

   always_comb begin
      cmd_new.op      = (req_data.action == llfl_pkg::ACT_POP) ? llfl_pkg::OP_POP
                                                               : llfl_pkg::OP_PUSH;
      cmd_new.payload = req_data.push_payload;
      wr_ptr_in       = put ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in       = get ? !rd_ptr_ff : rd_ptr_ff;
      fill_in         = fill_ff + 2'(put) - 2'(get);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (put) begin
         entries_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

@@ rtl/core/llfl_back.sv @@
module llfl_back #(
   parameter int POOL_NODES   = 256,
   parameter int PAYLOAD_BITS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  llfl_pkg::cmd_type cmd_data,
   output logic              cmd_take,
   output logic              rsp_strobe,
   output llfl_pkg::rsp_type rsp_data
);

   localparam int IW = $clog2(POOL_NODES);
   localparam int LW = IW + 1;
   localparam int FW = $clog2(POOL_NODES + 1);
   localparam logic [LW-1:0] LINK_NONE = {LW{1'b1}};
   localparam logic [LW-1:0] POOL_LIM  = LW'(POOL_NODES);
   localparam logic [IW-1:0] LAST_NODE = IW'(POOL_NODES - 1);

   logic [LW-1:0]           link_mem [POOL_NODES];
   logic [PAYLOAD_BITS-1:0] pay_mem  [POOL_NODES];

   llfl_pkg::back_state_type state_ff;
   llfl_pkg::back_state_type state_in;
   llfl_pkg::cmd_type        cmd_ff;
   llfl_pkg::cmd_type        cmd_in;
   logic [IW-1:0]            head_ff;
   logic [IW-1:0]            head_in;
   logic [IW-1:0]            tail_ff;
   logic [IW-1:0]            tail_in;
   logic [LW-1:0]            free_ff;
   logic [LW-1:0]            free_in;
   logic [IW-1:0]            count_ff;
   logic [IW-1:0]            count_in;
   logic [FW-1:0]            fresh_ff;
   logic [FW-1:0]            fresh_in;
   logic [IW-1:0]            addr_ff;
   logic [IW-1:0]            addr_in;
   logic [LW-1:0]            link_rd_ff;
   logic [PAYLOAD_BITS-1:0]  pay_rd_ff;
   logic                     rsp_strobe_ff;
   llfl_pkg::rsp_type        rsp_data_ff;

   logic                     link_re;
   logic [IW-1:0]            link_raddr;
   logic                     link_we;
   logic [IW-1:0]            link_waddr;
   logic [LW-1:0]            link_wdata;
   logic                     pay_re;
   logic [IW-1:0]            pay_raddr;
   logic                     pay_we;
   logic [IW-1:0]            pay_waddr;
   logic [PAYLOAD_BITS-1:0]  pay_wdata;
   logic [LW-1:0]            link_val;
   logic [IW-1:0]            node;
   logic                     rsp_fire;
   llfl_pkg::status_type     rsp_status;
   logic [63:0]              rsp_payload;
   logic [IW-1:0]            rsp_count;
   logic [16:0]              count_wide;

   // Nodes at or above the fresh mark were never taken, so their link still holds
   // the reset chain and is produced here instead of being read from memory.
   always_comb begin
      if (FW'(addr_ff) >= fresh_ff) begin
         link_val = (addr_ff == LAST_NODE) ? LINK_NONE : (LW'(addr_ff) + LW'(1));
      end else begin
         link_val = link_rd_ff;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      free_in     = free_ff;
      count_in    = count_ff;
      fresh_in    = fresh_ff;
      addr_in     = addr_ff;
      cmd_take    = 1'b0;
      link_re     = 1'b0;
      link_raddr  = '0;
      link_we     = 1'b0;
      link_waddr  = '0;
      link_wdata  = '0;
      pay_re      = 1'b0;
      pay_raddr   = '0;
      pay_we      = 1'b0;
      pay_waddr   = '0;
      pay_wdata   = '0;
      node        = '0;
      rsp_fire    = 1'b0;
      rsp_status  = llfl_pkg::ST_OK;
      rsp_payload = '0;
      rsp_count   = count_ff;

      unique case (state_ff)
         llfl_pkg::BK_IDLE, llfl_pkg::BK_PAY: begin
            if (state_ff == llfl_pkg::BK_PAY) begin
               rsp_fire    = 1'b1;
               rsp_payload = 64'(pay_rd_ff);
            end
            state_in = llfl_pkg::BK_IDLE;
            if (cmd_valid) begin
               cmd_take = 1'b1;
               cmd_in   = cmd_data;
               link_re  = 1'b1;
               if (cmd_data.op == llfl_pkg::OP_PUSH) begin
                  link_raddr = (free_ff < POOL_LIM) ? free_ff[IW-1:0] : '0;
               end else begin
                  link_raddr = head_ff;
               end
               addr_in  = link_raddr;
               state_in = llfl_pkg::BK_LINK;
            end
         end
         llfl_pkg::BK_LINK: begin
            state_in = llfl_pkg::BK_IDLE;
            if (cmd_ff.op == llfl_pkg::OP_PUSH) begin
               rsp_fire = 1'b1;
               if (free_ff >= POOL_LIM) begin
                  rsp_status = llfl_pkg::ST_FULL;
               end else begin
                  node       = free_ff[IW-1:0];
                  link_we    = 1'b1;
                  link_waddr = tail_ff;
                  link_wdata = LW'(node);
                  pay_we     = 1'b1;
                  pay_waddr  = node;
                  pay_wdata  = cmd_ff.payload[PAYLOAD_BITS-1:0];
                  free_in    = link_val;
                  tail_in    = node;
                  count_in   = count_ff + IW'(1);
                  if (FW'(node) == fresh_ff) begin
                     fresh_in = fresh_ff + FW'(1);
                  end
                  rsp_count  = count_in;
               end
            end else begin
               if (head_ff == tail_ff) begin
                  rsp_fire   = 1'b1;
                  rsp_status = llfl_pkg::ST_EMPTY;
               end else begin
                  node       = link_val[IW-1:0];
                  pay_re     = 1'b1;
                  pay_raddr  = node;
                  link_we    = 1'b1;
                  link_waddr = head_ff;
                  link_wdata = free_ff;
                  free_in    = LW'(head_ff);
                  head_in    = node;
                  count_in   = count_ff - IW'(1);
                  state_in   = llfl_pkg::BK_PAY;
               end
            end
         end
         default: begin
            state_in = llfl_pkg::BK_IDLE;
         end
      endcase

      count_wide = 17'(rsp_count);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= llfl_pkg::BK_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         free_ff       <= LW'(1);
         count_ff      <= '0;
         fresh_ff      <= FW'(1);
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         free_ff       <= free_in;
         count_ff      <= count_in;
         fresh_ff      <= fresh_in;
         rsp_strobe_ff <= rsp_fire;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      addr_ff <= addr_in;
      if (rsp_fire) begin
         rsp_data_ff.status      <= rsp_status;
         rsp_data_ff.pop_payload <= rsp_payload;
         rsp_data_ff.entry_count <= (count_wide > 17'd255) ? 8'hff : count_wide[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      if (link_re) begin
         link_rd_ff <= link_mem[link_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (pay_we) begin
         pay_mem[pay_waddr] <= pay_wdata;
      end
      if (pay_re) begin
         pay_rd_ff <= pay_mem[pay_raddr];
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

@@ rtl/core/linked_list_fifo_with_free_list_unit.sv @@
// Pushes and empty pops answer after the read of the link memory, other pops after a further
// read of the payload memory. Each access waits for one read of the link memory before the
// list pointers and the memories are updated.
// A two-word command queue lets start be taken while the previous access is still at work.
// Reset is synchronous: the free list above the highest node ever taken is implied by a
// fill mark, so the node memories need no clearing pass.
module linked_list_fifo_with_free_list_unit #(
   parameter int POOL_NODES   = 256,
   parameter int PAYLOAD_BITS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  llfl_pkg::req_type req_data,
   output logic              rsp_strobe,
   output llfl_pkg::rsp_type rsp_data
);

   logic              cmd_valid;
   llfl_pkg::cmd_type cmd_data;
   logic              cmd_take;

   llfl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_take  (cmd_take)
   );

   llfl_back #(
      .POOL_NODES   (POOL_NODES),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_data   (cmd_data),
      .cmd_take   (cmd_take),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   a_empty_has_no_entries: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_data.status == llfl_pkg::ST_EMPTY) |-> rsp_data.entry_count == 8'd0)
      else $error("empty status with entries held");

   a_failed_access_no_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_data.status != llfl_pkg::ST_OK) |-> rsp_data.pop_payload == 64'd0)
      else $error("payload on a failed access");

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("queue filled without a start");

   a_take_only_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> cmd_valid)
      else $error("back end took from an empty queue");

endmodule

@@ tb/llfl_access_tracker.sv @@
module llfl_access_tracker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  llfl_pkg::req_type req_data,
   input  logic              rsp_strobe,
   input  llfl_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending,
   output int                accepted_count,
   output int                full_rejects,
   output int                empty_rejects
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         NODES      = 256;
   localparam logic [8:0] NODE_NONE  = 9'h1FF;
   localparam int         REPORT_MAX = 10;

   logic [63:0] node_payload [NODES];
   logic [8:0]  node_link [NODES];
   logic [7:0]  head_node;
   logic [7:0]  tail_node;
   logic [8:0]  free_head;
   int          held_count;

   llfl_pkg::rsp_type predicted_rsp [$];
   int fails;
   int accepts;
   int fulls;
   int empties;

   function automatic void clear_list();
      for (int i = 0; i < NODES; i++) begin
         node_payload[i] = '0;
         node_link[i]    = (i + 1 < NODES) ? 9'(i + 1) : NODE_NONE;
      end
      node_link[0] = NODE_NONE;
      head_node    = '0;
      tail_node    = '0;
      free_head    = 9'd1;
      held_count   = 0;
   endfunction

   function automatic llfl_pkg::rsp_type apply_access(llfl_pkg::req_type word);
      llfl_pkg::rsp_type outcome;
      logic [8:0]        n;
      logic [7:0]        old_head;
      outcome.status      = llfl_pkg::ST_OK;
      outcome.pop_payload = '0;
      if (word.action == llfl_pkg::ACT_PUSH) begin
         n = free_head;
         if (n >= NODES) begin
            outcome.status = llfl_pkg::ST_FULL;
         end else begin
            free_head               = node_link[n[7:0]];
            node_payload[n[7:0]]    = word.push_payload;
            node_link[n[7:0]]       = NODE_NONE;
            node_link[tail_node]    = n;
            tail_node               = n[7:0];
            held_count++;
         end
      end else begin
         n = node_link[head_node];
         if (head_node == tail_node || n >= NODES) begin
            outcome.status = llfl_pkg::ST_EMPTY;
         end else begin
            outcome.pop_payload = node_payload[n[7:0]];
            old_head            = head_node;
            head_node           = n[7:0];
            node_link[old_head] = free_head;
            free_head           = {1'b0, old_head};
            if (held_count > 0) held_count--;
         end
      end
      outcome.entry_count = (held_count > 255) ? 8'hFF : 8'(held_count);
      return outcome;
   endfunction

   always @(posedge clock) begin
      llfl_pkg::rsp_type want;
      if (reset) begin
         clear_list();
         predicted_rsp.delete();
         fails   = 0;
         accepts = 0;
         fulls   = 0;
         empties = 0;
      end else begin
         if (start && !busy) begin
            predicted_rsp.push_back(apply_access(req_data));
            accepts++;
         end
         if (rsp_strobe) begin
            if (predicted_rsp.size() == 0) begin
               if (fails < REPORT_MAX)
                  $display("result word with no access pending: status %0d payload %h count %0d",
                           rsp_data.status, rsp_data.pop_payload, rsp_data.entry_count);
               fails++;
            end else begin
               want = predicted_rsp.pop_front();
               if (want.status == llfl_pkg::ST_FULL) fulls++;
               if (want.status == llfl_pkg::ST_EMPTY) empties++;
               if (rsp_data.status !== want.status ||
                   rsp_data.pop_payload !== want.pop_payload ||
                   rsp_data.entry_count !== want.entry_count) begin
                  if (fails < REPORT_MAX)
                     $display("mismatch: expected status %0d payload %h count %0d,",
                              want.status, want.pop_payload, want.entry_count,
                              " got status %0d payload %h count %0d",
                              rsp_data.status, rsp_data.pop_payload, rsp_data.entry_count);
                  fails++;
               end
            end
         end
      end
      fail_count     <= fails;
      pending        <= predicted_rsp.size();
      accepted_count <= accepts;
      full_rejects   <= fulls;
      empty_rejects  <= empties;
   end

endmodule

@@ tb/tb_linked_list_fifo_with_free_list_unit.sv @@
module tb_linked_list_fifo_with_free_list_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 1000;

   logic              clock    = 1'b0;
   logic              reset    = 1'b1;
   logic              start    = 1'b0;
   logic              busy;
   llfl_pkg::req_type req_data = '0;
   logic              rsp_strobe;
   llfl_pkg::rsp_type rsp_data;

   int fail_count;
   int pending;
   int accepted_count;
   int full_rejects;
   int empty_rejects;
   int quiet_cycles = 0;

   linked_list_fifo_with_free_list_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   llfl_access_tracker u_tracker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_data       (rsp_data),
      .fail_count     (fail_count),
      .pending        (pending),
      .accepted_count (accepted_count),
      .full_rejects   (full_rejects),
      .empty_rejects  (empty_rejects)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("linked_list_fifo_with_free_list_unit verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [63:0] pick_payload();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic send_word(input logic act, input logic [63:0] payload, input bit with_gaps);
      if (with_gaps) begin
         while ($urandom_range(99) < 12) begin
            @(negedge clock);
            start <= 1'b0;
         end
      end
      @(negedge clock);
      start                 <= 1'b1;
      req_data.action       <= act;
      req_data.push_payload <= payload;
      do @(posedge clock); while (busy);
   endtask

   task automatic run_mix(input int count, input int push_pct, input bit with_gaps);
      for (int i = 0; i < count; i++)
         send_word(($urandom_range(99) < push_pct) ? llfl_pkg::ACT_PUSH : llfl_pkg::ACT_POP,
                   pick_payload(), with_gaps);
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      send_word(llfl_pkg::ACT_POP, '1, 1'b1);
      send_word(llfl_pkg::ACT_POP, '0, 1'b1);
      send_word(llfl_pkg::ACT_PUSH, 64'h0, 1'b1);
      send_word(llfl_pkg::ACT_PUSH, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      send_word(llfl_pkg::ACT_PUSH, 64'h5555_5555_5555_5555, 1'b0);
      send_word(llfl_pkg::ACT_PUSH, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
      send_word(llfl_pkg::ACT_POP, pick_payload(), 1'b0);
      send_word(llfl_pkg::ACT_PUSH, 64'h8000_0000_0000_0001, 1'b0);
      send_word(llfl_pkg::ACT_POP, pick_payload(), 1'b1);
      send_word(llfl_pkg::ACT_POP, pick_payload(), 1'b0);
      send_word(llfl_pkg::ACT_POP, pick_payload(), 1'b0);
      send_word(llfl_pkg::ACT_POP, pick_payload(), 1'b1);
      send_word(llfl_pkg::ACT_POP, pick_payload(), 1'b0);
      send_word(llfl_pkg::ACT_PUSH, 64'h0000_0000_0000_0001, 1'b1);
      send_word(llfl_pkg::ACT_POP, pick_payload(), 1'b1);
      send_word(llfl_pkg::ACT_POP, pick_payload(), 1'b1);

      // Push-heavy traffic runs into the full pool, pop-heavy traffic drains it again.
      run_mix(380, 88, 1'b1);
      run_mix(200, 12, 1'b0);
      run_mix(180, 12, 1'b1);
      run_mix(290, 50, 1'b1);

      @(negedge clock);
      start <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Covered %0d accesses through fill to full and drain to empty.", accepted_count);
      $display("Rejected pushes on a full pool: %0d, pops on an empty queue: %0d.",
               full_rejects, empty_rejects);
      if (fail_count == 0 && pending == 0) begin
         $display("linked_list_fifo_with_free_list_unit verification clean");
      end else begin
         $display("linked_list_fifo_with_free_list_unit verification failed");
      end
      $finish;
   end

endmodule
